[rtl/fptw_pkg.sv]
package fptw_pkg;

  localparam int ENTRY_W = 64;
  localparam int IDX_W   = 9;
  localparam int ENTRIES = 512;

  localparam logic [63:0] ADDR_MASK    = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] BIT_PRESENT  = 64'h1;
  localparam logic [63:0] BIT_WRITABLE = 64'h2;

  typedef enum logic [1:0] {
    MODE_MAP       = 2'd0,
    MODE_UNMAP     = 2'd1,
    MODE_TRANSLATE = 2'd2,
    MODE_NONE      = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_NOFRAME  = 2'd2,
    ST_OUTSIDE  = 2'd3
  } status_t;

  localparam logic [1:0] REG_ROOT  = 2'd0;
  localparam logic [1:0] REG_BASE  = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

endpackage

[rtl/fptw_mem.sv]
module fptw_mem
  import fptw_pkg::*;
#(
  parameter int AW = 15
) (
  input  logic          clk,
  input  logic          rd,
  input  logic          wr,
  input  logic [AW-1:0] addr,
  input  logic [63:0]   wdata,
  output logic [63:0]   rdata
);

  logic [ENTRY_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[addr] <= wdata;
    end
    if (rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/four_level_page_table_walker.sv]
// page table walker over an on-chip frame memory of FRAMES frames x 512 64-bit
// entries. after reset a clearing pass zeroes the memory one entry per cycle
// (512 times FRAMES rounded up to a power of two entries) and no input beat is
// taken until it ends; configuration writes are accepted meanwhile. each item
// walks four dependent table levels through the single memory port, each read
// presenting the address and then using the registered data. a map that
// creates a missing table also zeroes the new frame with 512 zero writes and
// then writes the link. one item is in work at a time; the result sits in an
// output register so the next beat can be taken while it waits.
module four_level_page_table_walker
  import fptw_pkg::*;
#(
  parameter int FRAMES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // mode[1:0], vaddr[49:2], page_base[101:50], page_flags[113:102]
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], phys_result[53:2], freed_page[105:54], tlb_invalidate[106]
  output logic [111:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int FW  = $clog2(FRAMES);
  localparam int AW  = FW + IDX_W;
  // frame counter width, holds FRAMES itself and any root or allocator value
  localparam int FCW = (FW + 1 > 7) ? FW + 1 : 7;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_READ  = 9'b000000100,
    S_EVAL  = 9'b000001000,
    S_ZERO  = 9'b000010000,
    S_LINK  = 9'b000100000,
    S_LEAF  = 9'b001000000,
    S_DONE  = 9'b010000000,
    S_HOLD  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [5:0] root_r;
  logic [6:0] base_r, limit_r, nff_r;
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      REG_ROOT:  cfg_prdata = {26'd0, root_r};
      REG_BASE:  cfg_prdata = {25'd0, base_r};
      REG_LIMIT: cfg_prdata = {25'd0, limit_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // item registers
  logic [1:0]   mode_r;
  logic [47:0]  va_r;
  logic [51:0]  pa_r;
  logic [11:0]  flags_r;
  logic [1:0]   level_r;       // 0..2 intermediate, leaf handled in S_LEAF
  logic [FCW-1:0] frame_r;     // current table frame, may equal FRAMES
  logic [AW-1:0]  addr_r;      // clearing pass sweep pointer
  logic [IDX_W-1:0] zcnt_r;
  logic [FCW-1:0] nf_r;        // newly allocated frame
  logic         leaf_rd_r;

  // result register
  logic [111:0] res_r;
  logic         res_v_r;

  // memory port
  logic          m_rd, m_wr;
  logic [AW-1:0] m_addr;
  logic [63:0]   m_wdata, m_rdata;

  fptw_mem #(.AW(AW)) u_mem (
    .clk   (clk),
    .rd    (m_rd),
    .wr    (m_wr),
    .addr  (m_addr),
    .wdata (m_wdata),
    .rdata (m_rdata)
  );

  logic [IDX_W-1:0] cur_idx;
  always_comb begin
    case (level_r)
      2'd0:    cur_idx = va_r[47:39];
      2'd1:    cur_idx = va_r[38:30];
      2'd2:    cur_idx = va_r[29:21];
      default: cur_idx = va_r[20:12];
    endcase
  end

  logic [AW-1:0] walk_addr;
  assign walk_addr = {frame_r[FW-1:0], cur_idx};

  // frame field of a present entry, saturated to FRAMES
  logic [39:0]    ent_f;
  logic [FCW-1:0] ent_frame;
  assign ent_f     = m_rdata[51:12];
  assign ent_frame = (ent_f >= 40'(FRAMES)) ? FCW'(FRAMES) : FCW'(ent_f);

  logic can_alloc;
  assign can_alloc = (nff_r < limit_r) && (32'(nff_r) < FRAMES);

  logic out_free;
  assign out_free  = !res_v_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    m_rd    = 1'b0;
    m_wr    = 1'b0;
    m_addr  = walk_addr;
    m_wdata = '0;
    unique case (state_r)
      S_CLEAR: begin
        m_wr   = 1'b1;
        m_addr = addr_r;
      end
      S_READ: m_rd = 1'b1;
      S_ZERO: begin
        m_wr   = 1'b1;
        m_addr = {nf_r[FW-1:0], zcnt_r};
      end
      S_LINK: begin
        m_wr    = 1'b1;
        m_wdata = ({{(64-FCW){1'b0}}, nf_r} << 12) | BIT_PRESENT | BIT_WRITABLE;
      end
      S_LEAF: begin
        m_addr = {frame_r[FW-1:0], va_r[20:12]};
        if (mode_r == MODE_MAP) begin
          m_wr    = 1'b1;
          m_wdata = {12'd0, pa_r & ADDR_MASK[51:0]} | {52'd0, flags_r};
        end else begin
          m_rd = !leaf_rd_r;
          m_wr = leaf_rd_r && (mode_r == MODE_UNMAP) && m_rdata[0];
        end
      end
      default: ;
    endcase
  end

  function automatic logic [111:0] pack_res(logic [1:0] st, logic [51:0] ph,
                                            logic [51:0] fr, logic inv);
    return {5'd0, inv, fr, ph, st};
  endfunction

  logic         fin;
  logic [111:0] fin_data;

  always_comb begin
    state_nxt = state_r;
    fin       = 1'b0;
    fin_data  = '0;
    unique case (state_r)
      S_CLEAR: if (addr_r == AW'(2**AW - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_tvalid) begin
        if (in_tdata[1:0] == MODE_NONE) state_nxt = S_HOLD;
        else                            state_nxt = S_READ;
      end
      S_READ: begin
        if (32'(frame_r) >= FRAMES) begin
          fin = 1'b1; fin_data = pack_res(ST_OUTSIDE, '0, '0, 1'b0);
        end else if (level_r == 2'd3) begin
          state_nxt = S_LEAF;
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (m_rdata[0]) begin
          state_nxt = S_READ;
        end else if (mode_r != MODE_MAP) begin
          fin = 1'b1; fin_data = pack_res(ST_UNMAPPED, '0, '0, 1'b0);
        end else if (!can_alloc) begin
          fin = 1'b1; fin_data = pack_res(ST_NOFRAME, '0, '0, 1'b0);
        end else begin
          state_nxt = S_ZERO;
        end
      end
      S_ZERO: if (zcnt_r == IDX_W'(ENTRIES - 1)) state_nxt = S_LINK;
      S_LINK: state_nxt = S_READ;
      S_LEAF: begin
        if (mode_r == MODE_MAP) begin
          fin = 1'b1; fin_data = pack_res(ST_OK, '0, '0, 1'b1);
        end else if (leaf_rd_r) begin
          fin = 1'b1;
          if (!m_rdata[0])
            fin_data = pack_res(ST_UNMAPPED, '0, '0, 1'b0);
          else if (mode_r == MODE_UNMAP)
            fin_data = pack_res(ST_OK, '0, m_rdata[51:0] & ADDR_MASK[51:0], 1'b1);
          else
            fin_data = pack_res(ST_OK, {m_rdata[51:12], va_r[11:0]}, '0, 1'b0);
        end
      end
      S_HOLD: begin
        fin = 1'b1; fin_data = '0;
      end
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    // a finished item moves to S_DONE and waits there until the output is free
    if (fin) state_nxt = S_DONE;
  end

  // hold the result until the register can take it
  logic [111:0] pend_r;
  logic         pend_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      addr_r   <= '0;
      root_r   <= '0;
      base_r   <= 7'd1;
      limit_r  <= 7'd64;
      nff_r    <= 7'd1;
      res_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
      leaf_rd_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_ROOT:  root_r <= cfg_pwdata[5:0];
          REG_BASE: begin
            base_r <= cfg_pwdata[6:0];
            nff_r  <= cfg_pwdata[6:0];
          end
          REG_LIMIT: limit_r <= cfg_pwdata[6:0];
          default: ;
        endcase
      end
      if (state_r == S_CLEAR) addr_r <= addr_r + 1'b1;
      if (state_r == S_IDLE && in_tvalid) begin
        mode_r    <= in_tdata[1:0];
        va_r      <= in_tdata[49:2];
        pa_r      <= in_tdata[101:50];
        flags_r   <= in_tdata[113:102];
        level_r   <= 2'd0;
        frame_r   <= FCW'(root_r);
        leaf_rd_r <= 1'b0;
      end
      if (state_r == S_EVAL && m_rdata[0]) begin
        frame_r <= ent_frame;
        level_r <= level_r + 1'b1;
      end
      if (state_r == S_EVAL && !m_rdata[0] && mode_r == MODE_MAP && can_alloc) begin
        nf_r   <= FCW'(nff_r);
        nff_r  <= nff_r + 1'b1;
        zcnt_r <= '0;
      end
      if (state_r == S_ZERO) zcnt_r <= zcnt_r + 1'b1;
      if (state_r == S_LINK) begin
        frame_r <= nf_r;
        level_r <= level_r + 1'b1;
      end
      if (state_r == S_LEAF) leaf_rd_r <= 1'b1;
      if (fin) begin
        pend_r   <= fin_data;
        pend_v_r <= 1'b1;
      end
      // move pending result into the output register
      if (pend_v_r && out_free) begin
        res_r    <= pend_r;
        res_v_r  <= 1'b1;
        pend_v_r <= 1'b0;
      end else if (out_tvalid && out_tready) begin
        res_v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = res_v_r;
  assign out_tdata  = res_r;

  // no input beat is taken during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_tready)
    else $error("input taken while clearing");

  // a pending result is never overwritten
  a_pend_safe: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> !pend_v_r)
    else $error("pending result lost");

  // output stays valid until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped");

endmodule
